/* hw/rtl/aavr_pkg.sv */
package aavr_pkg;

   localparam int SincosStages = 16;
   localparam int CordicSteps  = (SincosStages > 24) ? 24 : SincosStages;
   localparam int CordicW      = 34;

   localparam logic signed [CordicW-1:0] CordicX0 = 34'sd652032874;

   function automatic logic signed [CordicW-1:0] atan_lookup(input logic [4:0] idx);
      logic signed [CordicW-1:0] r;
      case (idx)
         5'd0:  r = 34'sd536870912;
         5'd1:  r = 34'sd316933406;
         5'd2:  r = 34'sd167458907;
         5'd3:  r = 34'sd85004756;
         5'd4:  r = 34'sd42667331;
         5'd5:  r = 34'sd21354465;
         5'd6:  r = 34'sd10679838;
         5'd7:  r = 34'sd5340245;
         5'd8:  r = 34'sd2670163;
         5'd9:  r = 34'sd1335087;
         5'd10: r = 34'sd667544;
         5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;
         5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;
         5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;
         5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;
         5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;
         5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;
         5'd23: r = 34'sd81;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Payload carried alongside the sine/cosine pipeline.
   typedef struct packed {
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vz;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
   } vec_axis_type;

   typedef struct packed {
      logic signed [CordicW-1:0] x;
      logic signed [CordicW-1:0] y;
      logic signed [CordicW-1:0] z;
      logic                      flip;
   } cordic_type;

endpackage

/* hw/rtl/aavr_sincos.sv */
module aavr_sincos
   import aavr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [15:0]         phase,
   input  vec_axis_type        in_data,
   output logic                out_valid,
   output logic signed [15:0]  sin_q14,
   output logic signed [15:0]  cos_q14,
   output vec_axis_type        out_data
);

   cordic_type   stage_ff [CordicSteps+1];
   logic         vld_ff   [CordicSteps+1];
   vec_axis_type data_ff  [CordicSteps+1];

   logic                      flip_in;
   logic [15:0]               folded;
   logic signed [CordicW-1:0] xf;
   logic signed [CordicW-1:0] yf;
   logic signed [CordicW-1:0] xr;
   logic signed [CordicW-1:0] yr;

   assign flip_in = (phase >= 16'd16384) && (phase < 16'd49152);
   assign folded  = flip_in ? (phase - 16'd32768) : phase;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
      if (adv) begin
         stage_ff[0].x    <= CordicX0;
         stage_ff[0].y    <= '0;
         stage_ff[0].z    <= {{(CordicW-32){folded[15]}}, folded, 16'd0};
         stage_ff[0].flip <= flip_in;
         data_ff[0]       <= in_data;
      end
   end

   for (genvar i = 0; i < CordicSteps; i++) begin : g_step
      logic signed [CordicW-1:0] dx;
      logic signed [CordicW-1:0] dy;
      logic signed [CordicW-1:0] at;
      assign dx = stage_ff[i].y >>> i;
      assign dy = stage_ff[i].x >>> i;
      assign at = atan_lookup(5'(i));
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (adv) begin
            if (!stage_ff[i].z[CordicW-1]) begin
               stage_ff[i+1].x <= stage_ff[i].x - dx;
               stage_ff[i+1].y <= stage_ff[i].y + dy;
               stage_ff[i+1].z <= stage_ff[i].z - at;
            end else begin
               stage_ff[i+1].x <= stage_ff[i].x + dx;
               stage_ff[i+1].y <= stage_ff[i].y - dy;
               stage_ff[i+1].z <= stage_ff[i].z + at;
            end
            stage_ff[i+1].flip <= stage_ff[i].flip;
            data_ff[i+1]       <= data_ff[i];
         end
      end
   end

   assign xf = stage_ff[CordicSteps].flip ? -stage_ff[CordicSteps].x : stage_ff[CordicSteps].x;
   assign yf = stage_ff[CordicSteps].flip ? -stage_ff[CordicSteps].y : stage_ff[CordicSteps].y;
   assign xr = (xf + 34'sd32768) >>> 16;
   assign yr = (yf + 34'sd32768) >>> 16;

   always_comb begin
      if (xr > 34'sd16384)       cos_q14 = 16'sd16384;
      else if (xr < -34'sd16384) cos_q14 = -16'sd16384;
      else                       cos_q14 = xr[15:0];
      if (yr > 34'sd16384)       sin_q14 = 16'sd16384;
      else if (yr < -34'sd16384) sin_q14 = -16'sd16384;
      else                       sin_q14 = yr[15:0];
   end

   assign out_valid = vld_ff[CordicSteps];
   assign out_data  = data_ff[CordicSteps];

endmodule

/* hw/rtl/aavr_matrix.sv */
module aavr_matrix
   import aavr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic signed [15:0]  sin_q14,
   input  logic signed [15:0]  cos_q14,
   input  vec_axis_type        in_data,
   output logic                out_valid,
   output logic signed [17:0]  out_x,
   output logic signed [17:0]  out_y,
   output logic signed [17:0]  out_z,
   output logic                out_sat
);

   // Stage A: products of the axis with itself and with sin; 1-cos.
   logic               va_ff;
   logic signed [31:0] aa_ff [6];   // xx yy zz xy xz yz
   logic signed [31:0] sa_ff [3];
   logic signed [16:0] omc_ff;
   logic signed [15:0] c_ff;
   logic signed [15:0] v_a_ff [3];

   // Stage B: matrix entries at scale 2^-42.
   logic               vb_ff;
   logic signed [49:0] r_ff [9];
   logic signed [15:0] v_b_ff [3];

   // Stage C: nine products.
   logic               vc_ff;
   logic signed [65:0] p_ff [9];

   // Stage D: sums and rounding.
   logic               vd_ff;
   logic signed [17:0] o_ff [3];
   logic               sat_ff;

   logic signed [49:0] cd;
   logic signed [49:0] t [6];
   logic signed [49:0] s [3];

   assign cd = 50'(c_ff) <<< 28;
   always_comb begin
      for (int k = 0; k < 6; k++) t[k] = 50'(omc_ff) * 50'(aa_ff[k]);
      for (int k = 0; k < 3; k++) s[k] = 50'(sa_ff[k]) <<< 14;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [67:0] acc;
      logic               st;
      if (adv) begin
         aa_ff[0] <= in_data.ax * in_data.ax;
         aa_ff[1] <= in_data.ay * in_data.ay;
         aa_ff[2] <= in_data.az * in_data.az;
         aa_ff[3] <= in_data.ax * in_data.ay;
         aa_ff[4] <= in_data.ax * in_data.az;
         aa_ff[5] <= in_data.ay * in_data.az;
         sa_ff[0] <= sin_q14 * in_data.ax;
         sa_ff[1] <= sin_q14 * in_data.ay;
         sa_ff[2] <= sin_q14 * in_data.az;
         omc_ff   <= 17'sd16384 - 17'(cos_q14);
         c_ff     <= cos_q14;
         v_a_ff[0] <= in_data.vx;
         v_a_ff[1] <= in_data.vy;
         v_a_ff[2] <= in_data.vz;

         r_ff[0] <= t[0] + cd;
         r_ff[1] <= t[3] + s[2];
         r_ff[2] <= t[4] - s[1];
         r_ff[3] <= t[3] - s[2];
         r_ff[4] <= t[1] + cd;
         r_ff[5] <= t[5] + s[0];
         r_ff[6] <= t[4] + s[1];
         r_ff[7] <= t[5] - s[0];
         r_ff[8] <= t[2] + cd;
         v_b_ff  <= v_a_ff;

         for (int k = 0; k < 9; k++) begin
            p_ff[k] <= 66'(r_ff[k]) * 66'(v_b_ff[k % 3]);
         end

         st = 1'b0;
         for (int i = 0; i < 3; i++) begin
            acc = 68'(p_ff[3*i]) + 68'(p_ff[3*i+1]) + 68'(p_ff[3*i+2])
                  + (68'sd1 <<< 41);
            acc = acc >>> 42;
            if (acc > 68'sd131071) begin
               o_ff[i] <= 18'sd131071;
               st = 1'b1;
            end else if (acc < -68'sd131072) begin
               o_ff[i] <= -18'sd131072;
               st = 1'b1;
            end else begin
               o_ff[i] <= acc[17:0];
            end
         end
         sat_ff <= st;
      end
   end

   assign out_valid = vd_ff;
   assign out_x     = o_ff[0];
   assign out_y     = o_ff[1];
   assign out_z     = o_ff[2];
   assign out_sat   = sat_ff;

endmodule

/* hw/rtl/axis_angle_vector_rotation.sv */
// Path from an accepted request beat to its response beat:
// 17 CORDIC register stages, four matrix stages, one output register.
// Throughput: one beat per cycle; the whole pipeline advances together and holds on stall.
// Reset: synchronous, active high; clears all valid bits, payload registers are not reset.
module axis_angle_vector_rotation
   import aavr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_vec_x,
   input  logic signed [15:0]  req_vec_y,
   input  logic signed [15:0]  req_vec_z,
   input  logic signed [15:0]  req_axis_x,
   input  logic signed [15:0]  req_axis_y,
   input  logic signed [15:0]  req_axis_z,
   input  logic [15:0]         req_turn_phase,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [17:0]  rsp_out_x,
   output logic signed [17:0]  rsp_out_y,
   output logic signed [17:0]  rsp_out_z,
   output logic                rsp_saturated
);

   vec_axis_type      in_data;
   vec_axis_type      sc_data;
   logic              sc_valid;
   logic signed [15:0] s_q14;
   logic signed [15:0] c_q14;
   logic              mx_valid;
   logic signed [17:0] mx_x, mx_y, mx_z;
   logic              mx_sat;
   logic              adv;

   logic               ov_ff;
   logic signed [17:0] ox_ff, oy_ff, oz_ff;
   logic               os_ff;

   // The pipeline moves whenever the output register is empty or being drained.
   assign adv       = !ov_ff || rsp_ready;
   assign req_ready = adv;

   assign in_data = '{vx: req_vec_x, vy: req_vec_y, vz: req_vec_z,
                      ax: req_axis_x, ay: req_axis_y, az: req_axis_z};

   aavr_sincos u_sincos (
      .clock, .reset, .adv,
      .in_valid (req_valid),
      .phase    (req_turn_phase),
      .in_data,
      .out_valid(sc_valid),
      .sin_q14  (s_q14),
      .cos_q14  (c_q14),
      .out_data (sc_data)
   );

   aavr_matrix u_matrix (
      .clock, .reset, .adv,
      .in_valid (sc_valid),
      .sin_q14  (s_q14),
      .cos_q14  (c_q14),
      .in_data  (sc_data),
      .out_valid(mx_valid),
      .out_x    (mx_x),
      .out_y    (mx_y),
      .out_z    (mx_z),
      .out_sat  (mx_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= mx_valid;
      end
      if (adv) begin
         ox_ff <= mx_x;
         oy_ff <= mx_y;
         oz_ff <= mx_z;
         os_ff <= mx_sat;
      end
   end

   assign rsp_valid     = ov_ff;
   assign rsp_out_x     = ox_ff;
   assign rsp_out_y     = oy_ff;
   assign rsp_out_z     = oz_ff;
   assign rsp_saturated = os_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x))
      else $error("response changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline stalled with empty output");
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated}))
      else $error("unknown response payload");
`endif

endmodule
